FILE: hw/rtl/tlcd_pkg.sv
// tlcd_pkg: shared types, command codes and constant tables for the
// text lcd serial command encoder; no dependencies
package tlcd_pkg;

    localparam int DEF_COLS = 20;
    localparam int DEF_ROWS = 4;

    // request kinds
    localparam logic [1:0] REQ_CHAR     = 2'd0;
    localparam logic [1:0] REQ_BEGIN    = 2'd1;
    localparam logic [1:0] REQ_CONTRAST = 2'd2;
    localparam logic [1:0] REQ_NONE     = 2'd3;

    // display command bytes
    localparam logic [7:0] ESC_FIRST      = 8'h1e;
    localparam logic [7:0] ESC_SECOND     = 8'h01;
    localparam logic [7:0] CMD_GOTO       = 8'h11;
    localparam logic [7:0] CMD_RESTORE    = 8'h03;
    localparam logic [7:0] CMD_SCROLL_OFF = 8'h14;
    localparam logic [7:0] CMD_WRAP_OFF   = 8'h18;
    localparam logic [7:0] CMD_CONTRAST   = 8'h0f;
    localparam logic [7:0] GLYPH_SPACE    = 8'h20;
    localparam logic [7:0] RAW_LAST       = 8'h7d;
    localparam logic [20:0] CP_NEWLINE    = 21'd10;
    localparam logic [2:0] LEVEL_MAX      = 3'd4;

    // glyph table: rom entries first, then user glyphs
    localparam int SEARCH_N = 134;
    localparam int IDX_W    = $clog2(SEARCH_N);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_ESC0,
        S_ESC1,
        S_GLYPH,
        S_GOTO_CMD,
        S_GOTO_X,
        S_GOTO_Y,
        S_SPACE,
        S_RESTORE,
        S_SCROLL,
        S_WRAP,
        S_CONTR_CMD,
        S_CONTR_VAL
    } t_state;

    typedef struct packed {
        logic       done;
        logic [7:0] glyph;
    } t_search_res;

    function automatic logic [7:0] contrast_value(input logic [2:0] lvl);
        logic [7:0] v;
        unique case (lvl)
            3'd0:    v = 8'd0;
            3'd1:    v = 8'd55;
            3'd2:    v = 8'd65;
            3'd3:    v = 8'd70;
            3'd4:    v = 8'd75;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    // returns {code point (17 bits), glyph (8 bits)}
    function automatic logic [24:0] glyph_entry(input logic [IDX_W-1:0] idx);
        logic [24:0] e;
        unique case (idx)
            8'd0:   e = {17'h00024, 8'ha2};
            8'd1:   e = {17'h00040, 8'ha0};
            8'd2:   e = {17'h0005b, 8'hfa};
            8'd3:   e = {17'h0005c, 8'hfb};
            8'd4:   e = {17'h0005d, 8'hfc};
            8'd5:   e = {17'h0005e, 8'h0d};
            8'd6:   e = {17'h0005f, 8'hc4};
            8'd7:   e = {17'h00060, 8'h87};
            8'd8:   e = {17'h0007b, 8'hfd};
            8'd9:   e = {17'h0007c, 8'hfe};
            8'd10:  e = {17'h0007d, 8'hff};
            8'd11:  e = {17'h0007e, 8'hce};
            8'd12:  e = {17'h0007f, 8'hd6};
            8'd13:  e = {17'h025b6, 8'h10};
            8'd14:  e = {17'h025c0, 8'h11};
            8'd15:  e = {17'h000ab, 8'h14};
            8'd16:  e = {17'h000bb, 8'h15};
            8'd17:  e = {17'h02196, 8'h16};
            8'd18:  e = {17'h02197, 8'h17};
            8'd19:  e = {17'h02199, 8'h18};
            8'd20:  e = {17'h02198, 8'h19};
            8'd21:  e = {17'h025b2, 8'h1a};
            8'd22:  e = {17'h025bc, 8'h1b};
            8'd23:  e = {17'h023ce, 8'h1c};
            8'd24:  e = {17'h0258b, 8'h1f};
            8'd25:  e = {17'h000a4, 8'h24};
            8'd26:  e = {17'h000a1, 8'h40};
            8'd27:  e = {17'h000c4, 8'h5b};
            8'd28:  e = {17'h000d6, 8'h5c};
            8'd29:  e = {17'h000d1, 8'h5d};
            8'd30:  e = {17'h000dc, 8'h5e};
            8'd31:  e = {17'h000a7, 8'h5f};
            8'd32:  e = {17'h000bf, 8'h60};
            8'd33:  e = {17'h000e4, 8'h7b};
            8'd34:  e = {17'h000f6, 8'h7c};
            8'd35:  e = {17'h000f1, 8'h7d};
            8'd36:  e = {17'h000fc, 8'h7e};
            8'd37:  e = {17'h000e0, 8'h7f};
            8'd38:  e = {17'h02070, 8'h80};
            8'd39:  e = {17'h000b9, 8'h81};
            8'd40:  e = {17'h000b2, 8'h82};
            8'd41:  e = {17'h000b3, 8'h83};
            8'd42:  e = {17'h02074, 8'h84};
            8'd43:  e = {17'h02075, 8'h85};
            8'd44:  e = {17'h02076, 8'h86};
            8'd45:  e = {17'h02077, 8'h87};
            8'd46:  e = {17'h02078, 8'h88};
            8'd47:  e = {17'h02079, 8'h89};
            8'd48:  e = {17'h000bd, 8'h8a};
            8'd49:  e = {17'h000bc, 8'h8b};
            8'd50:  e = {17'h000b1, 8'h8c};
            8'd51:  e = {17'h02265, 8'h8d};
            8'd52:  e = {17'h02264, 8'h8e};
            8'd53:  e = {17'h000b5, 8'h8f};
            8'd54:  e = {17'h003bc, 8'h8f};
            8'd55:  e = {17'h0266a, 8'h90};
            8'd56:  e = {17'h0266b, 8'h91};
            8'd57:  e = {17'h1f514, 8'h92};
            8'd58:  e = {17'h1f56d, 8'h92};
            8'd59:  e = {17'h02665, 8'h93};
            8'd60:  e = {17'h025c6, 8'h94};
            8'd61:  e = {17'h1f4f6, 8'h95};
            8'd62:  e = {17'h0201c, 8'h98};
            8'd63:  e = {17'h0201d, 8'h99};
            8'd64:  e = {17'h003b1, 8'h9c};
            8'd65:  e = {17'h003b5, 8'h9d};
            8'd66:  e = {17'h003b4, 8'h9e};
            8'd67:  e = {17'h0221e, 8'h9f};
            8'd68:  e = {17'h000a3, 8'ha1};
            8'd69:  e = {17'h000a5, 8'ha3};
            8'd70:  e = {17'h000e8, 8'ha4};
            8'd71:  e = {17'h000e9, 8'ha5};
            8'd72:  e = {17'h000f9, 8'ha6};
            8'd73:  e = {17'h000ec, 8'ha7};
            8'd74:  e = {17'h000f2, 8'ha8};
            8'd75:  e = {17'h000e7, 8'ha9};
            8'd76:  e = {17'h000d8, 8'hab};
            8'd77:  e = {17'h000f8, 8'hac};
            8'd78:  e = {17'h00226, 8'hae};
            8'd79:  e = {17'h00227, 8'haf};
            8'd80:  e = {17'h000a2, 8'hb1};
            8'd81:  e = {17'h003c4, 8'hb3};
            8'd82:  e = {17'h003bb, 8'hb4};
            8'd83:  e = {17'h003a9, 8'hb5};
            8'd84:  e = {17'h003c0, 8'hb6};
            8'd85:  e = {17'h003a8, 8'hb7};
            8'd86:  e = {17'h003a3, 8'hb8};
            8'd87:  e = {17'h003b8, 8'hb9};
            8'd88:  e = {17'h0039e, 8'hba};
            8'd89:  e = {17'h025cf, 8'hbb};
            8'd90:  e = {17'h000c6, 8'hbc};
            8'd91:  e = {17'h000e6, 8'hbd};
            8'd92:  e = {17'h003b2, 8'hbe};
            8'd93:  e = {17'h000c9, 8'hbf};
            8'd94:  e = {17'h00393, 8'hc0};
            8'd95:  e = {17'h0039b, 8'hc1};
            8'd96:  e = {17'h003a0, 8'hc2};
            8'd97:  e = {17'h003d2, 8'hc3};
            8'd98:  e = {17'h000c8, 8'hc5};
            8'd99:  e = {17'h000ca, 8'hc6};
            8'd100: e = {17'h000ea, 8'hc7};
            8'd101: e = {17'h000e7, 8'hc8};
            8'd102: e = {17'h025c7, 8'hcf};
            8'd103: e = {17'h0258b, 8'hd0};
            8'd104: e = {17'h0258c, 8'hd1};
            8'd105: e = {17'h0258d, 8'hd2};
            8'd106: e = {17'h0258e, 8'hd3};
            8'd107: e = {17'h0258f, 8'hd4};
            8'd108: e = {17'h0258b, 8'hd6};
            8'd109: e = {17'h0258c, 8'hd7};
            8'd110: e = {17'h0258d, 8'hd8};
            8'd111: e = {17'h0258e, 8'hd9};
            8'd112: e = {17'h0258f, 8'hda};
            8'd113: e = {17'h020a7, 8'hdb};
            8'd114: e = {17'h02191, 8'hde};
            8'd115: e = {17'h02192, 8'hdf};
            8'd116: e = {17'h02193, 8'he0};
            8'd117: e = {17'h02190, 8'he1};
            8'd118: e = {17'h000c1, 8'he2};
            8'd119: e = {17'h000cd, 8'he3};
            8'd120: e = {17'h000d3, 8'he4};
            8'd121: e = {17'h000da, 8'he5};
            8'd122: e = {17'h000e1, 8'he7};
            8'd123: e = {17'h000ed, 8'he8};
            8'd124: e = {17'h000f3, 8'he9};
            8'd125: e = {17'h000fa, 8'hea};
            8'd126: e = {17'h000d4, 8'hec};
            8'd127: e = {17'h000f4, 8'hed};
            // user glyphs
            8'd128: e = {17'h000eb, 8'h00};
            8'd129: e = {17'h000ef, 8'h01};
            8'd130: e = {17'h003c3, 8'h02};
            8'd131: e = {17'h003c1, 8'h03};
            8'd132: e = {17'h000a9, 8'h04};
            8'd133: e = {17'h020ac, 8'h05};
            default: e = 25'd0;
        endcase
        return e;
    endfunction

endpackage

FILE: hw/rtl/tlcd_glyph_search.sv
// tlcd_glyph_search: walks the glyph table with one comparator, one entry
// per cycle, first match wins; depends on tlcd_pkg
module tlcd_glyph_search import tlcd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [20:0]   i_cp,
    output t_search_res   o_res
);

    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    logic [20:0]      r_cp;
    logic [24:0]      w_entry;
    logic             w_hit;
    logic             w_end;
    logic [7:0]       w_raw;

    // shared compare against the current table entry
    assign w_entry = glyph_entry(r_idx);
    assign w_hit   = (r_cp == {4'd0, w_entry[24:8]});
    assign w_end   = (r_idx == IDX_W'(SEARCH_N - 1));
    assign w_raw   = (r_cp >= 21'(GLYPH_SPACE) && r_cp <= 21'(RAW_LAST))
                     ? r_cp[7:0] : GLYPH_SPACE;

    always_comb begin
        o_res.done  = r_busy && (w_hit || w_end);
        o_res.glyph = w_hit ? w_entry[7:0] : w_raw;
    end

    // index sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy) begin
            if (w_hit || w_end) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cp <= i_cp;
        end
    end

endmodule

FILE: hw/rtl/text_lcd_serial_command_encoder.sv
// text_lcd_serial_command_encoder: top level, cursor tracking and byte
// sequencer; depends on tlcd_pkg and tlcd_glyph_search
//
// Usage: items arrive on the s channel (tuser = request kind, tdata = code
// point, log mode flag and contrast level). Each item yields zero or more
// display bytes on the m channel, one byte per item there, with tlast on
// the final byte caused by that input item.
// The input is taken only while the sequencer is idle; one input item is
// worked on at a time. A character item walks the 134-entry glyph table
// with one comparator, one entry per cycle, then emits at most 3 bytes.
// A newline emits up to COLS + 6 bytes, a begin item 6 and a contrast
// item 2, at one byte per cycle while the receiver keeps taking them.
// Items that emit nothing leave the sequencer idle.
// The output byte sits in a register; when the receiver stalls, the
// sequencer holds until that byte is taken, then continues.
// Reset (synchronous, active low) homes the cursor to column 0, row 0,
// selects normal (non-wrapping) mode and empties the output register.
module text_lcd_serial_command_encoder import tlcd_pkg::*; #(
    parameter int COLS = DEF_COLS,
    parameter int ROWS = DEF_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // [20:0] code_point, [21] log_mode, [24:22] level
    input  logic [1:0]  i_s_tuser,  // [1:0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,  // [7:0] tx_byte
    output logic        o_m_tlast
);

    localparam int COL_W = $clog2(COLS + 1);
    localparam int ROW_W = $clog2(ROWS + 1);
    localparam logic [COL_W-1:0] COL_END = COL_W'(COLS);
    localparam logic [ROW_W-1:0] ROW_END = ROW_W'(ROWS);

    t_state           r_state, n_state;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [ROW_W-1:0] r_ynext, n_ynext;
    logic             r_wrap, n_wrap;
    logic             r_fill, n_fill;
    logic [7:0]       r_glyph, n_glyph;
    logic [2:0]       r_level, n_level;
    logic             r_ovalid;
    logic [7:0]       r_obyte;
    logic             r_olast;

    logic        w_accept;
    logic        w_adv;
    logic        w_emit;
    logic [7:0]  w_byte;
    logic        w_last;
    logic        w_start;
    logic        w_esc;
    logic [ROW_W:0] w_row_inc;
    logic [ROW_W-1:0] w_ylog;
    logic [ROW_W-1:0] w_ynorm;
    t_search_res w_res;

    logic [1:0]  w_req;
    logic [20:0] w_cp;

    assign w_req    = i_s_tuser;
    assign w_cp     = i_s_tdata[20:0];
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_adv    = !r_ovalid || i_m_tready;
    assign w_start  = w_accept && (w_req == REQ_CHAR) && (w_cp != CP_NEWLINE)
                      && (r_col < COL_END) && (r_row < ROW_END);

    // next row for both newline modes
    assign w_row_inc = {1'b0, r_row} + 1'b1;
    always_comb begin
        if (w_row_inc >= (ROW_W + 1)'(ROWS)) begin
            w_ylog = (w_row_inc - (ROW_W + 1)'(ROWS) >= (ROW_W + 1)'(ROWS))
                     ? '0 : ROW_W'(w_row_inc - (ROW_W + 1)'(ROWS));
        end else begin
            w_ylog = ROW_W'(w_row_inc);
        end
        w_ynorm = (r_row < ROW_END) ? ROW_W'(w_row_inc) : ROW_END;
    end

    assign w_esc = (w_res.glyph < GLYPH_SPACE) ||
                   (w_res.glyph >= 8'd128 && w_res.glyph <= 8'd135);

    tlcd_glyph_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_cp    (w_cp),
        .o_res   (w_res)
    );

    // output decode per state
    always_comb begin
        w_emit = 1'b0;
        w_byte = 8'd0;
        w_last = 1'b0;
        unique case (r_state)
            S_ESC0:      begin w_emit = 1'b1; w_byte = ESC_FIRST; end
            S_ESC1:      begin w_emit = 1'b1; w_byte = ESC_SECOND; end
            S_GLYPH:     begin w_emit = 1'b1; w_byte = r_glyph; w_last = 1'b1; end
            S_GOTO_CMD:  begin w_emit = 1'b1; w_byte = CMD_GOTO; end
            S_GOTO_X:    begin w_emit = 1'b1; w_byte = 8'(r_col); end
            S_GOTO_Y:    begin
                w_emit = 1'b1;
                w_byte = 8'(r_row);
                w_last = !r_fill;
            end
            S_SPACE:     begin
                w_emit = 1'b1;
                w_byte = GLYPH_SPACE;
                w_last = (r_col == COL_W'(COLS - 1)) && !(r_ynext < ROW_END);
            end
            S_RESTORE:   begin w_emit = 1'b1; w_byte = CMD_RESTORE; end
            S_SCROLL:    begin w_emit = 1'b1; w_byte = CMD_SCROLL_OFF; end
            S_WRAP:      begin w_emit = 1'b1; w_byte = CMD_WRAP_OFF; end
            S_CONTR_CMD: begin w_emit = 1'b1; w_byte = CMD_CONTRAST; end
            S_CONTR_VAL: begin
                w_emit = 1'b1;
                w_byte = contrast_value(r_level);
                w_last = 1'b1;
            end
            default:     begin w_emit = 1'b0; end
        endcase
    end

    // next state and cursor update
    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_row   = r_row;
        n_ynext = r_ynext;
        n_wrap  = r_wrap;
        n_fill  = r_fill;
        n_glyph = r_glyph;
        n_level = r_level;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (w_req)
                        REQ_CHAR: begin
                            if (w_cp == CP_NEWLINE) begin
                                if (r_wrap) begin
                                    n_col   = '0;
                                    n_row   = w_ylog;
                                    n_ynext = w_ylog;
                                    n_fill  = 1'b1;
                                    n_state = S_GOTO_CMD;
                                end else if (r_row < ROW_END) begin
                                    n_ynext = w_ynorm;
                                    n_fill  = 1'b0;
                                    if (r_col < COL_END) begin
                                        n_state = S_SPACE;
                                    end else begin
                                        n_col = '0;
                                        n_row = w_ynorm;
                                        if (w_ynorm < ROW_END) begin
                                            n_state = S_GOTO_CMD;
                                        end
                                    end
                                end else begin
                                    n_col = '0;
                                    n_row = ROW_END;
                                end
                            end else if (w_start) begin
                                n_state = S_SEARCH;
                            end
                        end
                        REQ_BEGIN: begin
                            n_wrap  = i_s_tdata[21];
                            n_state = S_RESTORE;
                        end
                        REQ_CONTRAST: begin
                            n_level = i_s_tdata[24:22];
                            if (i_s_tdata[24:22] <= LEVEL_MAX) begin
                                n_state = S_CONTR_CMD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (w_res.done) begin
                    n_glyph = w_res.glyph;
                    n_state = w_esc ? S_ESC0 : S_GLYPH;
                end
            end
            S_ESC0:      if (w_adv) n_state = S_ESC1;
            S_ESC1:      if (w_adv) n_state = S_GLYPH;
            S_GLYPH: begin
                if (w_adv) begin
                    n_col   = r_col + 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_GOTO_CMD:  if (w_adv) n_state = S_GOTO_X;
            S_GOTO_X:    if (w_adv) n_state = S_GOTO_Y;
            S_GOTO_Y: begin
                if (w_adv) begin
                    n_fill  = 1'b0;
                    n_state = r_fill ? S_SPACE : S_IDLE;
                end
            end
            S_SPACE: begin
                if (w_adv) begin
                    if (r_col == COL_W'(COLS - 1)) begin
                        n_col   = '0;
                        n_row   = r_ynext;
                        n_state = (r_ynext < ROW_END) ? S_GOTO_CMD : S_IDLE;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            S_RESTORE:   if (w_adv) n_state = S_SCROLL;
            S_SCROLL:    if (w_adv) n_state = S_WRAP;
            S_WRAP: begin
                if (w_adv) begin
                    n_col   = '0;
                    n_row   = '0;
                    n_fill  = 1'b0;
                    n_state = S_GOTO_CMD;
                end
            end
            S_CONTR_CMD: if (w_adv) n_state = S_CONTR_VAL;
            S_CONTR_VAL: if (w_adv) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // control and cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_wrap  <= 1'b0;
            r_fill  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_wrap  <= n_wrap;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ynext <= n_ynext;
        r_glyph <= n_glyph;
        r_level <= n_level;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_adv) begin
            r_ovalid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_obyte <= w_byte;
            r_olast <= w_last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_obyte;
    assign o_m_tlast  = r_olast;

endmodule

FILE: hw/rtl/tlcd_checker.sv
// tlcd_checker: port-level assertions for the encoder top level, bound to
// it below; depends on tlcd_pkg
module tlcd_checker import tlcd_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [31:0] i_s_tdata,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [7:0]  o_m_tdata,
    input logic        o_m_tlast
);

    logic w_acc;
    assign w_acc = i_s_tvalid && o_s_tready;

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // a stalled byte holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast))
        else $error("stalled output changed");

    // a begin item always occupies the sequencer
    a_begin_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_s_tuser == REQ_BEGIN |=> !o_s_tready)
        else $error("begin item did not start a sequence");

    // an out-of-range contrast level emits nothing
    a_contrast_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_s_tuser == REQ_CONTRAST && i_s_tdata[24:22] > LEVEL_MAX
            |=> o_s_tready)
        else $error("ignored contrast item held the sequencer");

endmodule

bind text_lcd_serial_command_encoder tlcd_checker u_tlcd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

FILE: test/tb.sv
// tb: self-checking testbench for text_lcd_serial_command_encoder
// depends on tlcd_pkg and the encoder rtl; drives characters, begin, contrast and REQ_NONE items
module tb import tlcd_pkg::*;;

    localparam int NCOLS = DEF_COLS;
    localparam int NROWS = DEF_ROWS;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } t_lcd_byte;

    // glyph lookup written from the display character set
    function automatic int glyph_of(input logic [20:0] cp);
        case (cp)
            21'h24: return 8'ha2;   21'h40: return 8'ha0;   21'h5b: return 8'hfa;
            21'h5c: return 8'hfb;   21'h5d: return 8'hfc;   21'h5e: return 8'h0d;
            21'h5f: return 8'hc4;   21'h60: return 8'h87;   21'h7b: return 8'hfd;
            21'h7c: return 8'hfe;   21'h7d: return 8'hff;   21'h7e: return 8'hce;
            21'h7f: return 8'hd6;   21'h25b6: return 8'h10; 21'h25c0: return 8'h11;
            21'hab: return 8'h14;   21'hbb: return 8'h15;   21'h2196: return 8'h16;
            21'h2197: return 8'h17; 21'h2199: return 8'h18; 21'h2198: return 8'h19;
            21'h25b2: return 8'h1a; 21'h25bc: return 8'h1b; 21'h23ce: return 8'h1c;
            21'h258b: return 8'h1f; 21'ha4: return 8'h24;   21'ha1: return 8'h40;
            21'hc4: return 8'h5b;   21'hd6: return 8'h5c;   21'hd1: return 8'h5d;
            21'hdc: return 8'h5e;   21'ha7: return 8'h5f;   21'hbf: return 8'h60;
            21'he4: return 8'h7b;   21'hf6: return 8'h7c;   21'hf1: return 8'h7d;
            21'hfc: return 8'h7e;   21'he0: return 8'h7f;   21'h2070: return 8'h80;
            21'hb9: return 8'h81;   21'hb2: return 8'h82;   21'hb3: return 8'h83;
            21'h2074: return 8'h84; 21'h2075: return 8'h85; 21'h2076: return 8'h86;
            21'h2077: return 8'h87; 21'h2078: return 8'h88; 21'h2079: return 8'h89;
            21'hbd: return 8'h8a;   21'hbc: return 8'h8b;   21'hb1: return 8'h8c;
            21'h2265: return 8'h8d; 21'h2264: return 8'h8e; 21'hb5: return 8'h8f;
            21'h3bc: return 8'h8f;  21'h266a: return 8'h90; 21'h266b: return 8'h91;
            21'h1f514: return 8'h92; 21'h1f56d: return 8'h92; 21'h2665: return 8'h93;
            21'h25c6: return 8'h94; 21'h1f4f6: return 8'h95; 21'h201c: return 8'h98;
            21'h201d: return 8'h99; 21'h3b1: return 8'h9c;  21'h3b5: return 8'h9d;
            21'h3b4: return 8'h9e;  21'h221e: return 8'h9f; 21'ha3: return 8'ha1;
            21'ha5: return 8'ha3;   21'he8: return 8'ha4;   21'he9: return 8'ha5;
            21'hf9: return 8'ha6;   21'hec: return 8'ha7;   21'hf2: return 8'ha8;
            21'he7: return 8'ha9;   21'hd8: return 8'hab;   21'hf8: return 8'hac;
            21'h226: return 8'hae;  21'h227: return 8'haf;  21'ha2: return 8'hb1;
            21'h3c4: return 8'hb3;  21'h3bb: return 8'hb4;  21'h3a9: return 8'hb5;
            21'h3c0: return 8'hb6;  21'h3a8: return 8'hb7;  21'h3a3: return 8'hb8;
            21'h3b8: return 8'hb9;  21'h39e: return 8'hba;  21'h25cf: return 8'hbb;
            21'hc6: return 8'hbc;   21'he6: return 8'hbd;   21'h3b2: return 8'hbe;
            21'hc9: return 8'hbf;   21'h393: return 8'hc0;  21'h39b: return 8'hc1;
            21'h3a0: return 8'hc2;  21'h3d2: return 8'hc3;  21'hc8: return 8'hc5;
            21'hca: return 8'hc6;   21'hea: return 8'hc7;   21'h25c7: return 8'hcf;
            21'h258c: return 8'hd1; 21'h258d: return 8'hd2; 21'h258e: return 8'hd3;
            21'h258f: return 8'hd4; 21'h20a7: return 8'hdb; 21'h2191: return 8'hde;
            21'h2192: return 8'hdf; 21'h2193: return 8'he0; 21'h2190: return 8'he1;
            21'hc1: return 8'he2;   21'hcd: return 8'he3;   21'hd3: return 8'he4;
            21'hda: return 8'he5;   21'he1: return 8'he7;   21'hed: return 8'he8;
            21'hf3: return 8'he9;   21'hfa: return 8'hea;   21'hd4: return 8'hec;
            21'hf4: return 8'hed;
            // user glyphs
            21'heb: return 0;  21'hef: return 1;  21'h3c3: return 2;
            21'h3c1: return 3; 21'ha9: return 4;  21'h20ac: return 5;
            default: return -1;
        endcase
    endfunction

    // cursor model and queue of display bytes still owed by the encoder
    class lcd_scoreboard;
        int unsigned col, row;
        bit          wrap;
        t_lcd_byte   pending[$];
        t_lcd_byte   burst[$];
        int          errors, bytes_seen, items_seen;

        function void put(input logic [7:0] b);
            t_lcd_byte e;
            e.tx_byte = b;
            e.last = 1'b0;
            burst.push_back(e);
        endfunction

        function bit visible();
            return col < NCOLS && row < NROWS;
        endfunction

        function void move_to(input int unsigned x, input int unsigned y);
            col = x;
            row = y;
            if (visible()) begin
                put(CMD_GOTO);
                put(x[7:0]);
                put(y[7:0]);
            end
        endfunction

        function void show(input logic [7:0] g);
            if (!visible()) return;
            if (g < 32 || (g >= 128 && g <= 135)) begin
                put(ESC_FIRST);
                put(ESC_SECOND);
            end
            put(g);
            col++;
        endfunction

        function void note_item(input logic [1:0] kind, input logic [20:0] cp,
                                input logic lm, input logic [2:0] lvl);
            int g;
            int unsigned y;
            burst.delete();
            items_seen++;
            if (kind == REQ_CHAR) begin
                if (cp == CP_NEWLINE) begin
                    if (wrap) begin
                        y = (row + 1) % NROWS;
                        move_to(0, y);
                    end else begin
                        y = (row < NROWS) ? row + 1 : NROWS;
                    end
                    if (row < NROWS)
                        while (col < NCOLS) show(GLYPH_SPACE);
                    move_to(0, y);
                end else if (visible()) begin
                    g = glyph_of(cp);
                    if (g >= 0) begin
                        show(g[7:0]);
                    end else begin
                        put((cp < 32 || cp > RAW_LAST) ? GLYPH_SPACE : cp[7:0]);
                        col++;
                    end
                end
            end else if (kind == REQ_BEGIN) begin
                put(CMD_RESTORE);
                put(CMD_SCROLL_OFF);
                put(CMD_WRAP_OFF);
                wrap = lm;
                move_to(0, 0);
            end else if (kind == REQ_CONTRAST && lvl <= LEVEL_MAX) begin
                put(CMD_CONTRAST);
                case (lvl)
                    3'd0: put(8'd0);
                    3'd1: put(8'd55);
                    3'd2: put(8'd65);
                    3'd3: put(8'd70);
                    default: put(8'd75);
                endcase
            end
            if (burst.size() > 0) burst[$].last = 1'b1;
            foreach (burst[i]) pending.push_back(burst[i]);
        endfunction

        function void check_byte(input logic [7:0] b, input logic l);
            t_lcd_byte e;
            bytes_seen++;
            if (pending.size() == 0) begin
                $error("unexpected byte %h", b);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (b !== e.tx_byte) begin
                $error("tx_byte: expected %h, actual %h", e.tx_byte, b);
                errors++;
            end
            if (l !== e.last) begin
                $error("last: expected %0d, actual %0d", e.last, l);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;
    logic        o_m_tlast;

    lcd_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_off = 0;
    longint cycles = 0;

    text_lcd_serial_command_encoder dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_byte(o_m_tdata, o_m_tlast);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // offer one item, with random idle cycles before it; valid stays up
    // between back-to-back items
    task automatic send_item(input logic [1:0] kind, input logic [20:0] cp,
                             input logic lm, input logic [2:0] lvl);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= kind;
        i_s_tdata <= {7'd0, lvl, lm, cp};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_item(kind, cp, lm, lvl);
    endtask

    task automatic send_random();
        int r;
        logic [20:0] cp;
        r = $urandom_range(99);
        cp = 21'($urandom_range(32, 125));
        if (r < 10) cp = CP_NEWLINE;
        else if (r < 35) cp = 21'($urandom_range(161, 250));
        else if (r < 45) cp = 21'($urandom);
        else if (r < 50) cp = 21'($urandom_range(31));
        else if (r < 55) cp = 21'($urandom_range(16'h2190, 16'h25cf));
        if (r >= 94)
            send_item(REQ_BEGIN, 21'($urandom), 1'($urandom), 3'($urandom));
        else if (r >= 90)
            send_item(REQ_CONTRAST, 21'($urandom), 1'($urandom), 3'($urandom));
        else if (r == 89)
            send_item(REQ_NONE, 21'($urandom), 1'($urandom), 3'($urandom));
        else
            send_item(REQ_CHAR, cp, 1'($urandom), 3'($urandom));
    endtask

    initial begin
        int lat;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: commands, escapes, raw and unmapped points, both newline modes
        send_item(REQ_CONTRAST, 21'd0, 1'b0, 3'd0);
        send_item(REQ_CONTRAST, 21'h1fffff, 1'b1, 3'd4);
        send_item(REQ_CONTRAST, 21'd0, 1'b0, 3'd7);
        send_item(REQ_NONE, 21'd65, 1'b0, 3'd0);
        send_item(REQ_CHAR, 21'h25b6, 1'b0, 3'd0);
        send_item(REQ_CHAR, 21'h2070, 1'b0, 3'd0);
        send_item(REQ_CHAR, 21'heb, 1'b0, 3'd0);
        send_item(REQ_CHAR, 21'h1fffff, 1'b0, 3'd0);
        send_item(REQ_CHAR, 21'd32, 1'b0, 3'd0);
        send_item(REQ_CHAR, 21'd125, 1'b0, 3'd0);
        send_item(REQ_CHAR, 21'd0, 1'b0, 3'd0);
        send_item(REQ_CHAR, 21'h258b, 1'b0, 3'd0);
        for (int i = 0; i < 5; i++) send_item(REQ_CHAR, CP_NEWLINE, 1'b0, 3'd0);
        send_item(REQ_CHAR, 21'd65, 1'b0, 3'd0);
        send_item(REQ_BEGIN, 21'd0, 1'b1, 3'd0);
        for (int i = 0; i < 5; i++) send_item(REQ_CHAR, CP_NEWLINE, 1'b0, 3'd0);
        send_item(REQ_BEGIN, 21'd0, 1'b0, 3'd0);

        // random phases under different idling mixes
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            if (ph == 0) hold_off = 400;
            // NCOLS + 1 characters, one more than a line holds, then a newline
            for (int c = 0; c < NCOLS + 1; c++)
                send_item(REQ_CHAR, 21'($urandom_range(33, 125)), 1'b0, 3'd0);
            send_item(REQ_CHAR, CP_NEWLINE, 1'b0, 3'd0);
            for (int k = 0; k < 43; k++) send_random();
        end
        i_s_tvalid <= 1'b0;

        // drain
        recv_stall_pct = 0;
        while (sb.pending.size() > 0) @(posedge i_clk);
        lat = 0;
        while (lat < 300) begin
            @(posedge i_clk);
            lat++;
        end
        $display("covered %0d input items and %0d display bytes", sb.items_seen,
                 sb.bytes_seen);
        $display("normal and log newline modes, escapes, contrast and begin commands");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/tlcd_pkg.sv
hw/rtl/tlcd_glyph_search.sv
hw/rtl/text_lcd_serial_command_encoder.sv
hw/rtl/tlcd_checker.sv
test/tb.sv
